// ----- rtl/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared constants, codes and helpers of the byte histogram smoothing core.
// ----------------------------------------------------------------------------
package bhs_pkg;

	localparam int SYMBOLS     = 256;
	localparam int COUNT_WIDTH = 32;

	localparam int ADDR_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int ZCNT_W  = $clog2(SYMBOLS + 1);
	localparam int SYM_W   = 8;
	localparam int OP_W    = 2;
	localparam int TOTAL_W = 48;
	localparam int OUT_W   = 32;

	localparam logic [SYM_W:0]   SYM_LIMIT  = (SYM_W + 1)'(SYMBOLS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SYMBOLS - 1);
	localparam logic [ZCNT_W-1:0] ZCNT_INIT = ZCNT_W'(SYMBOLS);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [TOTAL_W-1:0]     total_t;

	typedef enum logic [OP_W-1:0] {
		OP_COUNT  = 2'd0,
		OP_ADJUST = 2'd1,
		OP_READ   = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_DRAIN,
		S_READ,
		S_MOD
	} bhs_state_t;

	function automatic count_t sat_count_inc(input count_t c);
		count_t r;
		if (&c) begin
			r = c;
		end else begin
			r = c + count_t'(1);
		end
		return r;
	endfunction

	function automatic total_t sat_total_add(input total_t t, input total_t n);
		logic [TOTAL_W:0] sum;
		total_t           r;
		sum = {1'b0, t} + {1'b0, n};
		if (sum[TOTAL_W]) begin
			r = '1;
		end else begin
			r = sum[TOTAL_W-1:0];
		end
		return r;
	endfunction

	// Clamp a counter to the 32-bit report width
	function automatic logic [OUT_W-1:0] clamp_out(input count_t c);
		logic [OUT_W-1:0] r;
		if (COUNT_WIDTH > OUT_W && (c >> OUT_W) != count_t'(0)) begin
			r = '1;
		end else begin
			r = OUT_W'(c);
		end
		return r;
	endfunction

endpackage

// ----- rtl/bhs_ram.sv -----
// ----------------------------------------------------------------------------
// bhs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/byte_histogram_smoothing_core.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_smoothing_core
// Per-byte saturating occurrence counters with add-one smoothing.
// ----------------------------------------------------------------------------
// Counters live in a single-read, single-write RAM of SYMBOLS words; a
// per-entry valid flag makes the whole table read as zero straight after
// reset, so no clearing pass is needed. Count and read items read the
// counter when accepted, then update it and load the result register. An
// adjust item that finds a zero counter walks the RAM with a read-modify-write
// sweep, then reads its own symbol and loads the result; an adjust item with
// no zero counter is handled like a read. The sweep visits one address per
// read, as the counter RAM has one read port. A zero-counter tally is kept
// so the adjust decision needs no scan. One result register lets a new item
// be taken while the previous result waits on out_ready.
module byte_histogram_smoothing_core
	import bhs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    operation,
	input  logic [SYM_W-1:0]   symbol,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_W-1:0]   symbol_count,
	output logic [TOTAL_W-1:0] total_count,
	output logic               adjusted
);

	bhs_state_t state_q, state_d;

	logic [OP_W-1:0]    op_q;
	logic [SYM_W-1:0]   sym_q;
	logic               adj_q;
	logic [ADDR_W-1:0]  sweep_ptr_q;
	logic [ZCNT_W-1:0]  zero_cnt_q;
	total_t             total_q;
	logic [SYMBOLS-1:0] valid_q;

	logic               sweep_rd_s1;
	logic [ADDR_W-1:0]  sweep_addr_s1;
	logic               valid_s1;

	logic               out_valid_q;
	logic [OUT_W-1:0]   symbol_count_q;
	total_t             total_count_q;
	logic               adjusted_q;

	logic               accept;
	logic               out_free;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	count_t             rd_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	count_t             cur_count;
	count_t             inc_count;
	logic               in_range;
	logic               is_count;
	logic               mod_commit;
	logic               mod_wr;
	logic               start_sweep;
	total_t             total_d;

	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign in_range  = {1'b0, sym_q} < SYM_LIMIT;
	assign is_count  = (op_q == OP_COUNT);
	assign cur_count = valid_s1 ? rd_data : count_t'(0);
	assign inc_count = sat_count_inc(cur_count);
	assign start_sweep = (operation == OP_ADJUST) && (zero_cnt_q != ZCNT_W'(0));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = start_sweep ? S_SWEEP : S_MOD;
				end
			end
			S_SWEEP: begin
				if (sweep_ptr_q == LAST_ADDR) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_READ;
			S_READ:  state_d = S_MOD;
			S_MOD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = sym_q[ADDR_W-1:0];
		mod_commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
				rd_addr  = symbol[ADDR_W-1:0];
			end
			S_SWEEP: begin
				rd_en   = 1'b1;
				rd_addr = sweep_ptr_q;
			end
			S_READ: begin
				rd_en = 1'b1;
			end
			S_MOD: begin
				mod_commit = out_free;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign mod_wr  = mod_commit && is_count && in_range;
	assign wr_en   = sweep_rd_s1 || mod_wr;
	assign wr_addr = sweep_rd_s1 ? sweep_addr_s1 : sym_q[ADDR_W-1:0];

	always_comb begin
		total_d = total_q;
		if (adj_q) begin
			total_d = sat_total_add(total_q, TOTAL_W'(SYMBOLS));
		end else if (is_count && in_range) begin
			total_d = sat_total_add(total_q, TOTAL_W'(1));
		end
	end

	bhs_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(SYMBOLS)
	) u_counters (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(inc_count),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sweep_rd_s1 <= 1'b0;
			zero_cnt_q  <= ZCNT_INIT;
			total_q     <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sweep_rd_s1 <= (state_q == S_SWEEP);
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			// a sweep lifts every counter off zero
			if (accept && start_sweep) begin
				zero_cnt_q <= '0;
			end else if (mod_wr && cur_count == count_t'(0)) begin
				zero_cnt_q <= zero_cnt_q - ZCNT_W'(1);
			end
			if (mod_commit) begin
				total_q     <= total_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= operation;
			sym_q       <= symbol;
			adj_q       <= start_sweep;
			sweep_ptr_q <= '0;
		end else if (state_q == S_SWEEP) begin
			sweep_ptr_q <= sweep_ptr_q + ADDR_W'(1);
		end
		sweep_addr_s1 <= sweep_ptr_q;
		if (rd_en) begin
			valid_s1 <= valid_q[rd_addr];
		end
		if (mod_commit) begin
			if (!in_range) begin
				symbol_count_q <= '0;
			end else if (mod_wr) begin
				symbol_count_q <= clamp_out(inc_count);
			end else begin
				symbol_count_q <= clamp_out(cur_count);
			end
			total_count_q <= total_d;
			adjusted_q    <= adj_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol_count = symbol_count_q;
	assign total_count  = total_count_q;
	assign adjusted     = adjusted_q;

endmodule

// ----- sim/tb_byte_histogram_smoothing_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_histogram_smoothing_core
// Drives count, adjust, read and spare items into the histogram core, keeps a
// private copy of the per-byte counters and the running total, and compares
// every result in order. Both handshakes idle at random; the receiver also
// holds off for a long stretch, and the sender drains once mid-run.
// ----------------------------------------------------------------------------
module tb_byte_histogram_smoothing_core;
	import bhs_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          ITEM_TOTAL  = 1950;
	localparam int          HOLDOFF_CYC = 400;
	localparam longint unsigned REPORT_MAX = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [OUT_W-1:0] symbol_count;
		total_t           total_count;
		logic             adjusted;
	} histogram_result_t;

	class histogram_tracker;
		count_t              tally[SYMBOLS];
		total_t              running_total;
		histogram_result_t   due_results[$];
		int unsigned         mismatches;
		int unsigned         results_seen;

		function new();
			foreach (tally[i]) tally[i] = '0;
			running_total = '0;
			mismatches    = 0;
			results_seen  = 0;
		endfunction

		function count_t step_count(input count_t c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		function total_t add_total(input total_t t, input total_t n);
			total_t top;
			top = '1;
			return (n > top - t) ? top : t + n;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		function void note_item(input op_t op, input logic [SYM_W-1:0] sym);
			histogram_result_t r;
			bit                any_zero;
			longint unsigned   wide;
			r = '0;
			any_zero = 1'b0;
			case (op)
				OP_COUNT: begin
					// out-of-range symbols leave the table and the total alone
					if (int'(sym) < SYMBOLS) begin
						tally[sym]    = step_count(tally[sym]);
						running_total = add_total(running_total, total_t'(1));
					end
				end
				OP_ADJUST: begin
					foreach (tally[i]) if (tally[i] == '0) any_zero = 1'b1;
					if (any_zero) begin
						foreach (tally[i]) tally[i] = step_count(tally[i]);
						running_total = add_total(running_total, total_t'(SYMBOLS));
						r.adjusted = 1'b1;
					end
				end
				default: ;
			endcase
			if (int'(sym) < SYMBOLS) begin
				wide = 64'(tally[sym]);
				r.symbol_count = (wide > REPORT_MAX) ? '1 : OUT_W'(wide);
			end
			r.total_count = running_total;
			due_results.push_back(r);
		endfunction

		function void check_result(input logic [OUT_W-1:0] sc, input total_t tc,
				input logic adj);
			histogram_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, symbol_count %0d total_count %0d adjusted %0b",
					$time, sc, tc, adj);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			results_seen++;
			if (sc !== want.symbol_count) begin
				$display("%0t: symbol_count expected %0d actual %0d",
					$time, want.symbol_count, sc);
				mismatches++;
			end
			if (tc !== want.total_count) begin
				$display("%0t: total_count expected %0d actual %0d",
					$time, want.total_count, tc);
				mismatches++;
			end
			if (adj !== want.adjusted) begin
				$display("%0t: adjusted expected %0b actual %0b",
					$time, want.adjusted, adj);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [OP_W-1:0]    operation = '0;
	logic [SYM_W-1:0]   symbol    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [OUT_W-1:0]   symbol_count;
	logic [TOTAL_W-1:0] total_count;
	logic               adjusted;

	histogram_tracker tracker = new();
	int unsigned      cycle_count = 0;
	int unsigned      holdoff_left = 0;
	bit               holdoff_done = 1'b0;

	byte_histogram_smoothing_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.symbol       (symbol),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol_count (symbol_count),
		.total_count  (total_count),
		.adjusted     (adjusted)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: check results, hold off once for a long stretch, idle at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_result(symbol_count, total_count, adjusted);
		end
		if (!holdoff_done && tracker.results_seen >= 300) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF_CYC;
		end
		if (holdoff_left != 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else if (tracker.results_seen >= 880 && tracker.results_seen < 1180) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 36);
		end
	end

	task automatic offer(input op_t op, input logic [SYM_W-1:0] sym);
		in_valid  <= 1'b1;
		operation <= op;
		symbol    <= sym;
		do @(posedge clk); while (!in_ready);
		tracker.note_item(op, sym);
	endtask

	task automatic idle_after(input bit steady);
		int unsigned gap = 0;
		if (!steady) begin
			while ($urandom_range(99) < 36) gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		op_t             op;
		logic [SYM_W-1:0] sym;
		int unsigned     pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, field extremes, spare code, adjust with and without zeros
		offer(OP_READ, 8'h00);    idle_after(1'b0);
		offer(OP_READ, 8'hFF);    idle_after(1'b0);
		offer(OP_COUNT, 8'h00);   idle_after(1'b0);
		offer(OP_COUNT, 8'hFF);   idle_after(1'b0);
		offer(OP_COUNT, 8'hFF);   idle_after(1'b0);
		offer(OP_COUNT, 8'hA5);   idle_after(1'b0);
		offer(OP_COUNT, 8'h5A);   idle_after(1'b0);
		offer(OP_SPARE, 8'hFF);   idle_after(1'b0);
		offer(OP_READ, 8'h5A);    idle_after(1'b0);
		offer(OP_ADJUST, 8'h00);  idle_after(1'b0);
		offer(OP_READ, 8'h01);    idle_after(1'b0);
		offer(OP_ADJUST, 8'hFF);  idle_after(1'b0);
		offer(OP_COUNT, 8'h01);   idle_after(1'b0);
		offer(OP_READ, 8'hA5);    idle_after(1'b0);
		offer(OP_SPARE, 8'h00);   idle_after(1'b0);
		offer(OP_ADJUST, 8'h80);  idle_after(1'b0);
		offer(OP_COUNT, 8'h7F);
		drain();

		for (int i = 0; i < ITEM_TOTAL; i++) begin
			pick = $urandom_range(99);
			if (pick < 58) op = OP_COUNT;
			else if (pick < 80) op = OP_READ;
			else if (pick < 90) op = OP_ADJUST;
			else op = OP_SPARE;
			// favour a few hot bytes at either end so their counters climb
			if ($urandom_range(1) == 0) begin
				sym = 8'($urandom_range(255));
			end else begin
				sym = 8'($urandom_range(3));
				if ($urandom_range(1) == 1) sym = sym | 8'hFC;
			end
			offer(op, sym);
			if (i == 1400) begin
				drain();
			end else begin
				idle_after(i >= 900 && i < 1200);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/bhs_pkg.sv
rtl/bhs_ram.sv
rtl/byte_histogram_smoothing_core.sv
sim/tb_byte_histogram_smoothing_core.sv
